// ===== hw/rtl/bcrs_pkg.sv =====
package bcrs_pkg;

   localparam int CHAN_W = 8;
   localparam int COLOR_W = 3 * CHAN_W;
   localparam int SIZE_CFG_W = 9;
   localparam int RADIUS_CFG_W = 10;
   localparam int TOL_CFG_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 10;
   localparam int COORD_W = 16;
   localparam int CALC_W = 18;
   localparam int RADIUS_SQ_W = 19;
   localparam int LIMIT_W = 18;
   localparam int DIST_W = 19;

   localparam logic [RADIUS_CFG_W-1:0] RADIUS_LIMIT = 10'd512;
   localparam logic [1:0] DIST_FACTOR = 2'd3;
   localparam logic [CHAN_W-1:0] SELECTED_VALUE = 8'd255;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_STROKE = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_LOAD = 2'd1;
   localparam logic [1:0] KIND_STROKE = 2'd2;
   localparam logic [1:0] KIND_READ = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE = 2'd3;

   function automatic logic [RADIUS_CFG_W-1:0] radius_eff(input logic [RADIUS_CFG_W-1:0] r);
      logic [RADIUS_CFG_W-1:0] v;
      if (r == '0) begin
         v = 10'd1;
      end else if (r > RADIUS_LIMIT) begin
         v = RADIUS_LIMIT;
      end else begin
         v = r;
      end
      return v;
   endfunction

endpackage

// ===== hw/rtl/bcrs_ram.sv =====
module bcrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bcrs_fifo.sv =====
module bcrs_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/bcrs_front.sv =====
module bcrs_front #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
   localparam int ENTRY_W = 3 + bcrs_pkg::COLOR_W + 3 * XW + 3 * YW
) (
   input  logic [1:0]                              req_op,
   input  logic signed [bcrs_pkg::COORD_W-1:0]     req_x_coord,
   input  logic signed [bcrs_pkg::COORD_W-1:0]     req_y_coord,
   input  logic [bcrs_pkg::CHAN_W-1:0]             req_blue,
   input  logic [bcrs_pkg::CHAN_W-1:0]             req_green,
   input  logic [bcrs_pkg::CHAN_W-1:0]             req_red,
   input  logic [bcrs_pkg::SIZE_CFG_W-1:0]         cfg_width,
   input  logic [bcrs_pkg::SIZE_CFG_W-1:0]         cfg_height,
   input  logic [bcrs_pkg::RADIUS_CFG_W-1:0]       cfg_radius,
   output logic [ENTRY_W-1:0]                      entry
);

   localparam int EWW = $clog2(MAX_WIDTH + 1);
   localparam int EHW = $clog2(MAX_HEIGHT + 1);
   localparam int CW = bcrs_pkg::CALC_W;

   logic [EWW-1:0]        eff_w;
   logic [EHW-1:0]        eff_h;
   logic signed [CW-1:0]  xs, ys, wm1, hm1, rs;
   logic signed [CW-1:0]  sx, sy, xlo, xhi, ylo, yhi, x0, x1, y0, y1;
   logic                  in_image;
   logic [1:0]            kind;
   logic                  status;

   always_comb begin
      if (cfg_width == '0) begin
         eff_w = EWW'(1);
      end else if (32'(cfg_width) > MAX_WIDTH) begin
         eff_w = EWW'(MAX_WIDTH);
      end else begin
         eff_w = EWW'(cfg_width);
      end
      if (cfg_height == '0) begin
         eff_h = EHW'(1);
      end else if (32'(cfg_height) > MAX_HEIGHT) begin
         eff_h = EHW'(MAX_HEIGHT);
      end else begin
         eff_h = EHW'(cfg_height);
      end
   end

   always_comb begin
      xs = CW'(req_x_coord);
      ys = CW'(req_y_coord);
      wm1 = $signed(CW'(eff_w)) - CW'(1);
      hm1 = $signed(CW'(eff_h)) - CW'(1);
      rs = $signed(CW'(bcrs_pkg::radius_eff(cfg_radius)));
      sx = (xs < 0) ? CW'(0) : ((xs > wm1) ? wm1 : xs);
      sy = (ys < 0) ? CW'(0) : ((ys > hm1) ? hm1 : ys);
      xlo = sx - rs;
      xhi = sx + rs;
      ylo = sy - rs;
      yhi = sy + rs;
      x0 = (xlo < 0) ? CW'(0) : xlo;
      x1 = (xhi > wm1) ? wm1 : xhi;
      y0 = (ylo < 0) ? CW'(0) : ylo;
      y1 = (yhi > hm1) ? hm1 : yhi;
      in_image = (xs >= 0) && (xs <= wm1) && (ys >= 0) && (ys <= hm1);
   end

   always_comb begin
      kind = bcrs_pkg::KIND_NONE;
      status = 1'b0;
      unique case (req_op)
         bcrs_pkg::OP_LOAD: begin
            kind = in_image ? bcrs_pkg::KIND_LOAD : bcrs_pkg::KIND_NONE;
            status = !in_image;
         end
         bcrs_pkg::OP_STROKE: begin
            kind = bcrs_pkg::KIND_STROKE;
         end
         bcrs_pkg::OP_READ: begin
            kind = in_image ? bcrs_pkg::KIND_READ : bcrs_pkg::KIND_NONE;
            status = !in_image;
         end
         default: begin
            kind = bcrs_pkg::KIND_NONE;
         end
      endcase
   end

   assign entry = {kind, status, XW'(sx), YW'(sy), req_red, req_green, req_blue,
                   XW'(x0), XW'(x1), YW'(y0), YW'(y1)};

endmodule

// ===== hw/rtl/bcrs_back.sv =====
module bcrs_back #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
   localparam int ENTRY_W = 3 + bcrs_pkg::COLOR_W + 3 * XW + 3 * YW
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_not_empty,
   input  logic [ENTRY_W-1:0]                 q_data,
   output logic                               q_pop,
   input  logic [bcrs_pkg::RADIUS_CFG_W-1:0]  cfg_radius,
   input  logic [bcrs_pkg::TOL_CFG_W-1:0]     cfg_tolerance,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bcrs_pkg::CHAN_W-1:0]        rsp_mask_value,
   output logic                               rsp_status
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RAM_DEPTH = (DEPTH > 1) ? DEPTH : 2;
   localparam int DW = ((XW > YW) ? XW : YW) + 2;
   localparam int SQW = 2 * DW + 1;
   localparam int CMPW = (SQW > bcrs_pkg::RADIUS_SQ_W) ? SQW : bcrs_pkg::RADIUS_SQ_W;
   localparam int CW = bcrs_pkg::COLOR_W;
   localparam int HW = bcrs_pkg::CHAN_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ_WAIT = 3'd1;
   localparam logic [2:0] ST_SEED_WAIT = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [1:0]    e_kind;
   logic          e_status;
   logic [XW-1:0] e_x, e_x0, e_x1;
   logic [YW-1:0] e_y, e_y0, e_y1;
   logic [CW-1:0] e_color;

   assign {e_kind, e_status, e_x, e_y, e_color, e_x0, e_x1, e_y0, e_y1} = q_data;

   logic [2:0]    state_ff, state_in;
   logic [XW-1:0] sx_ff, sx_in, x0_ff, x0_in, x1_ff, x1_in, cx_ff, cx_in;
   logic [YW-1:0] sy_ff, sy_in, y1_ff, y1_in, cy_ff, cy_in;
   logic [CW-1:0] seed_ff, seed_in;
   logic [HW-1:0] res_mask_ff, res_mask_in;
   logic          res_status_ff, res_status_in;
   logic          pv_ff, pv_in, pdisc_ff, pdisc_in;
   logic [AW-1:0] paddr_ff, paddr_in;
   logic [bcrs_pkg::RADIUS_SQ_W-1:0] r2_ff;
   logic [bcrs_pkg::LIMIT_W-1:0]     limit_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [HW-1:0] rsp_mask_ff, rsp_mask_in;
   logic          rsp_status_ff, rsp_status_in;

   logic          pix_wr_en, pix_rd_en, sel_wr_en, sel_rd_en, sel_wr_data;
   logic [AW-1:0] pix_rd_addr, sel_wr_addr, sel_rd_addr, entry_addr, sweep_addr;
   logic [CW-1:0] pix_rd_data;
   logic          sel_rd_data;

   logic signed [DW-1:0]  dx, dy;
   logic [SQW-1:0]        disc_sum;
   logic                  in_disc;
   logic signed [HW:0]    db, dg, dr;
   logic [bcrs_pkg::DIST_W-1:0] color_dist;
   logic                  hit;
   logic [bcrs_pkg::RADIUS_CFG_W-1:0] r_eff;

   assign entry_addr = AW'(AW'(e_y) * AW'(MAX_WIDTH)) + AW'(e_x);
   assign sweep_addr = AW'(AW'(cy_ff) * AW'(MAX_WIDTH)) + AW'(cx_ff);
   assign r_eff = bcrs_pkg::radius_eff(cfg_radius);

   always_comb begin
      dx = $signed(DW'(cx_ff)) - $signed(DW'(sx_ff));
      dy = $signed(DW'(cy_ff)) - $signed(DW'(sy_ff));
      disc_sum = SQW'(dx * dx) + SQW'(dy * dy);
      in_disc = CMPW'(disc_sum) <= CMPW'(r2_ff);
      db = $signed({1'b0, pix_rd_data[HW-1:0]}) - $signed({1'b0, seed_ff[HW-1:0]});
      dg = $signed({1'b0, pix_rd_data[2*HW-1:HW]}) - $signed({1'b0, seed_ff[2*HW-1:HW]});
      dr = $signed({1'b0, pix_rd_data[CW-1:2*HW]}) - $signed({1'b0, seed_ff[CW-1:2*HW]});
      color_dist = bcrs_pkg::DIST_W'(db * db) + bcrs_pkg::DIST_W'(dg * dg)
                   + bcrs_pkg::DIST_W'(dr * dr);
      hit = pv_ff && pdisc_ff && (color_dist <= bcrs_pkg::DIST_W'(limit_ff));
   end

   always_comb begin
      state_in = state_ff;
      sx_in = sx_ff;
      sy_in = sy_ff;
      x0_in = x0_ff;
      x1_in = x1_ff;
      y1_in = y1_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      seed_in = seed_ff;
      res_mask_in = res_mask_ff;
      res_status_in = res_status_ff;
      pv_in = 1'b0;
      pdisc_in = in_disc;
      paddr_in = sweep_addr;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_mask_in = rsp_mask_ff;
      rsp_status_in = rsp_status_ff;
      q_pop = 1'b0;
      pix_wr_en = 1'b0;
      pix_rd_en = 1'b0;
      pix_rd_addr = entry_addr;
      sel_wr_en = hit;
      sel_wr_addr = paddr_ff;
      sel_wr_data = 1'b1;
      sel_rd_en = 1'b0;
      sel_rd_addr = entry_addr;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop = 1'b1;
               res_mask_in = '0;
               res_status_in = e_status;
               sx_in = e_x;
               sy_in = e_y;
               x0_in = e_x0;
               x1_in = e_x1;
               y1_in = e_y1;
               cx_in = e_x0;
               cy_in = e_y0;
               unique case (e_kind)
                  bcrs_pkg::KIND_LOAD: begin
                     pix_wr_en = 1'b1;
                     sel_wr_en = 1'b1;
                     sel_wr_addr = entry_addr;
                     sel_wr_data = 1'b0;
                     state_in = ST_DONE;
                  end
                  bcrs_pkg::KIND_READ: begin
                     sel_rd_en = 1'b1;
                     state_in = ST_READ_WAIT;
                  end
                  bcrs_pkg::KIND_STROKE: begin
                     pix_rd_en = 1'b1;
                     state_in = ST_SEED_WAIT;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            res_mask_in = sel_rd_data ? bcrs_pkg::SELECTED_VALUE : '0;
            state_in = ST_DONE;
         end
         ST_SEED_WAIT: begin
            seed_in = pix_rd_data;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            pix_rd_en = 1'b1;
            pix_rd_addr = sweep_addr;
            pv_in = 1'b1;
            if (cx_ff == x1_ff) begin
               cx_in = x0_ff;
               if (cy_ff == y1_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  cy_in = cy_ff + YW'(1);
               end
            end else begin
               cx_in = cx_ff + XW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in = res_mask_ff;
               rsp_status_in = res_status_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      x0_ff <= x0_in;
      x1_ff <= x1_in;
      y1_ff <= y1_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      seed_ff <= seed_in;
      res_mask_ff <= res_mask_in;
      res_status_ff <= res_status_in;
      pdisc_ff <= pdisc_in;
      paddr_ff <= paddr_in;
      r2_ff <= bcrs_pkg::RADIUS_SQ_W'(r_eff * r_eff);
      limit_ff <= bcrs_pkg::LIMIT_W'(bcrs_pkg::DIST_FACTOR * cfg_tolerance * cfg_tolerance);
      rsp_mask_ff <= rsp_mask_in;
      rsp_status_ff <= rsp_status_in;
   end

   bcrs_ram #(.WIDTH(CW), .DEPTH(RAM_DEPTH)) u_pixel_ram (
      .clock   (clock),
      .wr_en   (pix_wr_en),
      .wr_addr ($clog2(RAM_DEPTH)'(entry_addr)),
      .wr_data (e_color),
      .rd_en   (pix_rd_en),
      .rd_addr ($clog2(RAM_DEPTH)'(pix_rd_addr)),
      .rd_data (pix_rd_data)
   );

   bcrs_ram #(.WIDTH(1), .DEPTH(RAM_DEPTH)) u_select_ram (
      .clock   (clock),
      .wr_en   (sel_wr_en),
      .wr_addr ($clog2(RAM_DEPTH)'(sel_wr_addr)),
      .wr_data (sel_wr_data),
      .rd_en   (sel_rd_en),
      .rd_addr ($clog2(RAM_DEPTH)'(sel_rd_addr)),
      .rd_data (sel_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mask_value = rsp_mask_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== hw/rtl/brush_color_region_select.sv =====
// Image memory with a brush selection map. Load and read words pass through the
// two-entry queue and are then handled by the back end. A stroke word reads its
// seed pixel, then walks the clamped square window around the point one pixel
// per cycle through the pixel memory read port. Neither memory is cleared after
// reset; reading a pixel that was never loaded gives undefined data.
module brush_color_region_select #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_op,
   input  logic signed [bcrs_pkg::COORD_W-1:0]    req_x_coord,
   input  logic signed [bcrs_pkg::COORD_W-1:0]    req_y_coord,
   input  logic [bcrs_pkg::CHAN_W-1:0]            req_blue,
   input  logic [bcrs_pkg::CHAN_W-1:0]            req_green,
   input  logic [bcrs_pkg::CHAN_W-1:0]            req_red,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [bcrs_pkg::CHAN_W-1:0]            rsp_mask_value,
   output logic                                   rsp_status,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bcrs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bcrs_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int ENTRY_W = 3 + bcrs_pkg::COLOR_W + 3 * XW + 3 * YW;

   logic [bcrs_pkg::SIZE_CFG_W-1:0]   width_ff, height_ff;
   logic [bcrs_pkg::RADIUS_CFG_W-1:0] radius_ff;
   logic [bcrs_pkg::TOL_CFG_W-1:0]    tolerance_ff;
   logic [ENTRY_W-1:0]                push_entry, pop_entry;
   logic                              q_full, q_not_empty, q_pop;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256;
         height_ff <= 9'd256;
         radius_ff <= 10'd1;
         tolerance_ff <= 8'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            bcrs_pkg::CSR_WIDTH: width_ff <= csr_wdata[bcrs_pkg::SIZE_CFG_W-1:0];
            bcrs_pkg::CSR_HEIGHT: height_ff <= csr_wdata[bcrs_pkg::SIZE_CFG_W-1:0];
            bcrs_pkg::CSR_RADIUS: radius_ff <= csr_wdata;
            bcrs_pkg::CSR_TOLERANCE: tolerance_ff <= csr_wdata[bcrs_pkg::TOL_CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   bcrs_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .req_op      (req_op),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .req_blue    (req_blue),
      .req_green   (req_green),
      .req_red     (req_red),
      .cfg_width   (width_ff),
      .cfg_height  (height_ff),
      .cfg_radius  (radius_ff),
      .entry       (push_entry)
   );

   bcrs_fifo #(.WIDTH(ENTRY_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_entry)
   );

   bcrs_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_data         (pop_entry),
      .q_pop          (q_pop),
      .cfg_radius     (radius_ff),
      .cfg_tolerance  (tolerance_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mask_value (rsp_mask_value),
      .rsp_status     (rsp_status)
   );

endmodule
